### rtl/tmva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmva_pkg
// Shared types, constants and width helpers of the mixed voronoi area unit.
// ----------------------------------------------------------------------------
package tmva_pkg;

  localparam int AREA_W     = 31;
  localparam int DIM_W      = 2;
  localparam logic [DIM_W-1:0] DIM_2D    = 2'd2;
  localparam logic [DIM_W-1:0] DIM_RESET = 2'd3;
  // output scale exponents: eighth-sum case and half-area case
  localparam int EIGHTH_EXP = 13;
  localparam int HALF_EXP   = 14;

  typedef struct packed {
    logic valid;
    logic degen;
  } tmva_tag_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int shift_l(input int s);
    return (s < 0) ? -2 * s : 0;
  endfunction

  function automatic int shift_r(input int s);
    return (s > 0) ? 2 * s : 0;
  endfunction

  // squared cross length width
  function automatic int s_width(input int cb);
    return 2 * (2 * (cb + 1) + 1) + 2;
  endfunction

  // numerator width of the eighth-sum case
  function automatic int n_width(input int cb);
    return 2 * (2 * (cb + 1) + 2);
  endfunction

  function automatic int l_width(input int cb, input int fb);
    return s_width(cb) + imax(shift_l(EIGHTH_EXP - 2 * fb), shift_l(HALF_EXP - 2 * fb)) + 1;
  endfunction

  function automatic int r_width(input int cb, input int fb);
    return 2 * n_width(cb) + imax(shift_r(EIGHTH_EXP - 2 * fb), shift_r(HALF_EXP - 2 * fb));
  endfunction

endpackage

### rtl/tmva_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmva channel interfaces
// Triangle input channel and corner area output channel, valid/ready.
// ----------------------------------------------------------------------------
interface tmva_tri_if #(parameter int COORD_BITS = 16);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] v0_x;
  logic signed [COORD_BITS-1:0] v0_y;
  logic signed [COORD_BITS-1:0] v0_z;
  logic signed [COORD_BITS-1:0] v1_x;
  logic signed [COORD_BITS-1:0] v1_y;
  logic signed [COORD_BITS-1:0] v1_z;
  logic signed [COORD_BITS-1:0] v2_x;
  logic signed [COORD_BITS-1:0] v2_y;
  logic signed [COORD_BITS-1:0] v2_z;

  modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  input ready);
  modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                output ready);
endinterface

interface tmva_area_if;
  logic        valid;
  logic        ready;
  logic [30:0] area_at_v0;
  logic [30:0] area_at_v1;
  logic [30:0] area_at_v2;
  logic        degenerate;

  modport source (output valid, area_at_v0, area_at_v1, area_at_v2, degenerate,
                  input ready);
  modport sink (input valid, area_at_v0, area_at_v1, area_at_v2, degenerate,
                output ready);
endinterface

### rtl/tmva_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmva_front
// Edge, cross, dot and numerator pipeline; builds the root search operands.
// ----------------------------------------------------------------------------
module tmva_front #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8,
  parameter int LW         = 79,
  parameter int RW         = 144
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic                         drop_z,
  input  logic signed [COORD_BITS-1:0] coord [3][3],
  output tmva_pkg::tmva_tag_t          tag,
  output logic [LW-1:0]                l_val [3],
  output logic [RW-1:0]                r_val [3]
);
  import tmva_pkg::*;

  localparam int EW    = COORD_BITS + 1;
  localparam int PW    = 2 * EW;
  localparam int XW    = PW + 1;
  localparam int DW    = PW + 2;
  localparam int QW    = PW + 2;
  localparam int SW    = 2 * XW + 2;
  localparam int PDW   = QW + DW - 1;
  localparam int NW    = PDW + 1;
  localparam int H     = (NW + 1) / 2;
  localparam int HW    = NW - H;
  localparam int NSQ   = 2 * NW;
  localparam int NS    = EIGHTH_EXP - 2 * FRAC_BITS;
  localparam int OS    = HALF_EXP - 2 * FRAC_BITS;
  localparam int LSH_N = shift_l(NS);
  localparam int LSH_O = shift_l(OS);
  localparam int RSH_N = shift_r(NS);
  localparam int RSH_O = shift_r(OS);

  logic va, vb, vc, vd, ve, vf;

  // stage a: edges
  logic signed [EW-1:0] vx [3][3];
  logic signed [EW-1:0] ea [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        if (k == 2 && drop_z) begin
          vx[i][k] = '0;
        end else begin
          vx[i][k] = {coord[i][k][COORD_BITS-1], coord[i][k]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ea[0][k] <= vx[2][k] - vx[1][k];
        ea[1][k] <= vx[0][k] - vx[2][k];
        ea[2][k] <= vx[1][k] - vx[0][k];
      end
    end
  end

  // stage b: coordinate products
  logic signed [PW-1:0] xt0 [3];
  logic signed [PW-1:0] xt1 [3];
  logic signed [PW-1:0] dp [3][3];
  logic signed [PW-1:0] sp [3][3];

  for (genvar k = 0; k < 3; k++) begin : g_cross
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;
    always_ff @(posedge clk) begin
      if (en) begin
        xt0[k] <= ea[2][K1] * ea[1][K2];
        xt1[k] <= ea[2][K2] * ea[1][K1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_corner_b
    localparam int I1 = (i + 1) % 3;
    localparam int I2 = (i + 2) % 3;
    for (genvar k = 0; k < 3; k++) begin : g_coord
      always_ff @(posedge clk) begin
        if (en) begin
          dp[i][k] <= ea[I2][k] * ea[I1][k];
          sp[i][k] <= ea[i][k] * ea[i][k];
        end
      end
    end
  end

  // stage c: cross components, corner dots, squared edge lengths
  logic signed [XW-1:0] cx [3];
  logic signed [DW-1:0] dt [3];
  logic [QW-1:0]        sq [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        cx[k] <= XW'(xt0[k]) - XW'(xt1[k]);
      end
      for (int i = 0; i < 3; i++) begin
        // corner dot uses outgoing edges, so the sign flips
        dt[i] <= -(DW'(dp[i][0]) + DW'(dp[i][1]) + DW'(dp[i][2]));
        sq[i] <= QW'(DW'(sp[i][0]) + DW'(sp[i][1]) + DW'(sp[i][2]));
      end
    end
  end

  // stage d: cross squares, length times dot
  logic [2*XW-1:0] cs [3];
  logic [PDW-1:0]  pd [3];
  logic [2:0]      neg_d;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        cs[k]    <= cx[k] * cx[k];
        pd[k]    <= sq[k] * dt[k][DW-2:0];
        neg_d[k] <= dt[k][DW-1];
      end
    end
  end

  // stage e: squared double area, numerators, obtuse pick
  logic [SW-1:0] s_e;
  logic [NW-1:0] n_e [3];
  logic [2:0]    half_e;
  logic          obt_e;

  for (genvar i = 0; i < 3; i++) begin : g_num
    localparam int I1 = (i + 1) % 3;
    localparam int I2 = (i + 2) % 3;
    always_ff @(posedge clk) begin
      if (en) begin
        n_e[i] <= NW'(pd[I1]) + NW'(pd[I2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_e       <= SW'(cs[0]) + SW'(cs[1]) + SW'(cs[2]);
      half_e[0] <= neg_d[0];
      half_e[1] <= !neg_d[0] && neg_d[1];
      half_e[2] <= !neg_d[0] && !neg_d[1] && neg_d[2];
      obt_e     <= |neg_d;
    end
  end

  // stage f: numerator square as partial products
  logic [2*HW-1:0]   hh [3];
  logic [HW+H-1:0]   hl [3];
  logic [2*H-1:0]    ll [3];
  logic [SW-1:0]     s_f;
  logic [2:0]        half_f;
  logic              obt_f;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hh[i] <= n_e[i][NW-1:H] * n_e[i][NW-1:H];
        hl[i] <= n_e[i][NW-1:H] * n_e[i][H-1:0];
        ll[i] <= n_e[i][H-1:0] * n_e[i][H-1:0];
      end
      s_f    <= s_e;
      half_f <= half_e;
      obt_f  <= obt_e;
    end
  end

  // stage g: search operands
  logic [NSQ-1:0] n2 [3];
  logic [LW-1:0]  lb;
  logic [RW-1:0]  rb [3];

  always_comb begin
    lb = obt_f ? LW'(1) : LW'(s_f);
    for (int i = 0; i < 3; i++) begin
      n2[i] = (NSQ'(hh[i]) << (2 * H)) + (NSQ'(hl[i]) << (H + 1)) + NSQ'(ll[i]);
      rb[i] = obt_f ? RW'(s_f) : RW'(n2[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        l_val[i] <= half_f[i] ? (lb << LSH_O) : (lb << LSH_N);
        r_val[i] <= half_f[i] ? (rb[i] << RSH_O) : (rb[i] << RSH_N);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      ve        <= 1'b0;
      vf        <= 1'b0;
      tag.valid <= 1'b0;
    end else if (en) begin
      va        <= in_valid;
      vb        <= va;
      vc        <= vb;
      vd        <= vc;
      ve        <= vd;
      vf        <= ve;
      tag.valid <= vf;
      tag.degen <= (s_f == '0);
    end
  end

endmodule

### rtl/tmva_root_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmva_root_lane
// Pipelined bit search: largest q below 2^31 with q*q*l <= r, one bit a stage.
// ----------------------------------------------------------------------------
module tmva_root_lane #(
  parameter int LW = 79,
  parameter int RW = 144
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [LW-1:0]               l_val,
  input  logic [RW-1:0]               r_val,
  output logic [tmva_pkg::AREA_W-1:0] q
);
  import tmva_pkg::*;

  localparam int AW  = AREA_W;
  localparam int PLW = LW + AW;
  localparam int CWD = imax(RW, LW + 2 * AW + 1) + 1;

  logic [LW-1:0]  ls [AW+1];
  logic [RW-1:0]  rs [AW+1];
  logic [PLW-1:0] ps [AW+1];
  logic [AW-1:0]  qs [AW+1];

  assign ls[0] = l_val;
  assign rs[0] = r_val;
  assign ps[0] = '0;
  assign qs[0] = '0;

  // rs holds r - q*q*l, ps holds q*l
  for (genvar j = 0; j < AW; j++) begin : g_stage
    localparam int B = AW - 1 - j;
    logic [CWD-1:0] delta;
    logic           take;

    always_comb begin
      delta = (CWD'(ps[j]) << (B + 1)) + (CWD'(ls[j]) << (2 * B));
      take  = (delta <= CWD'(rs[j]));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ls[j+1] <= ls[j];
        rs[j+1] <= take ? (rs[j] - delta[RW-1:0]) : rs[j];
        ps[j+1] <= take ? (ps[j] + (PLW'(ls[j]) << B)) : ps[j];
        qs[j+1] <= take ? (qs[j] | (AW'(1) << B)) : qs[j];
      end
    end
  end

  assign q = qs[AW];

endmodule

### rtl/triangle_mixed_voronoi_area_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_mixed_voronoi_area_unit
// Pipeline: 7 geometry stages, 31 root search stages and 1 output register
//   lie between input transaction and result.
// Throughput: one triangle per cycle; the whole pipeline holds while a result
//   waits at the output.
// Reset: clears all valid flags; dimension returns to 3.
// ----------------------------------------------------------------------------
module triangle_mixed_voronoi_area_unit #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [tmva_pkg::DIM_W-1:0]    cfg_wr_data,
  tmva_tri_if.sink                      tri_in,
  tmva_area_if.source                   area_out
);
  import tmva_pkg::*;

  localparam int LW = l_width(COORD_BITS, FRAC_BITS);
  localparam int RW = r_width(COORD_BITS, FRAC_BITS);
  localparam int AW = AREA_W;

  logic [DIM_W-1:0]              dimension;
  logic                          advance;
  logic signed [COORD_BITS-1:0]  coord [3][3];
  tmva_tag_t                     front_tag;
  tmva_tag_t                     tags [AW+1];
  logic [LW-1:0]                 l_val [3];
  logic [RW-1:0]                 r_val [3];
  logic [AW-1:0]                 q [3];
  logic                          o_valid;
  logic [AW-1:0]                 o_area [3];
  logic                          o_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= DIM_RESET;
    end else if (cfg_wr_en) begin
      dimension <= cfg_wr_data;
    end
  end

  assign advance      = !o_valid || area_out.ready;
  assign tri_in.ready = advance;

  assign coord[0][0] = tri_in.v0_x;
  assign coord[0][1] = tri_in.v0_y;
  assign coord[0][2] = tri_in.v0_z;
  assign coord[1][0] = tri_in.v1_x;
  assign coord[1][1] = tri_in.v1_y;
  assign coord[1][2] = tri_in.v1_z;
  assign coord[2][0] = tri_in.v2_x;
  assign coord[2][1] = tri_in.v2_y;
  assign coord[2][2] = tri_in.v2_z;

  tmva_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .LW         (LW),
    .RW         (RW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .in_valid (tri_in.valid),
    .drop_z   (dimension == DIM_2D),
    .coord    (coord),
    .tag      (front_tag),
    .l_val    (l_val),
    .r_val    (r_val)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    tmva_root_lane #(
      .LW (LW),
      .RW (RW)
    ) u_lane (
      .clk   (clk),
      .en    (advance),
      .l_val (l_val[i]),
      .r_val (r_val[i]),
      .q     (q[i])
    );
  end

  // tag rides alongside the lanes
  assign tags[0] = front_tag;

  for (genvar j = 0; j < AW; j++) begin : g_tag
    always_ff @(posedge clk) begin
      if (rst) begin
        tags[j+1].valid <= 1'b0;
      end else if (advance) begin
        tags[j+1].valid <= tags[j].valid;
        tags[j+1].degen <= tags[j].degen;
      end
    end
  end

  // merge: degenerate triangles give zero areas
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= tags[AW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_degen <= tags[AW].degen;
      for (int i = 0; i < 3; i++) begin
        o_area[i] <= tags[AW].degen ? '0 : q[i];
      end
    end
  end

  assign area_out.valid      = o_valid;
  assign area_out.area_at_v0 = o_area[0];
  assign area_out.area_at_v1 = o_area[1];
  assign area_out.area_at_v2 = o_area[2];
  assign area_out.degenerate = o_degen;

endmodule
